[src/sle_pkg.sv]
// Shared codes, constants and result type of the serial link frame engine.
`default_nettype none

package sle_pkg;

  // Input action codes.
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_COMMIT = 2'd1;
  localparam logic [1:0] ACT_XFER   = 2'd2;

  // Link frame constants.
  localparam logic [15:0] SYNC_WORD = 16'hFEFE;
  localparam logic [15:0] SUM_BIAS  = 16'h0010;
  localparam logic [15:0] PASS_SUM  = 16'hFFEF;

  // One result item without the send word, which comes from the frame store.
  typedef struct packed {
    logic        send_valid;
    logic        start_next;
    logic [3:0]  rx_position;
    logic        rx_valid;
    logic [15:0] rx_word0;
    logic [15:0] rx_word1;
    logic        frame_done;
    logic [1:0]  slot_ok;
    logic        link_error;
  } sle_result_t;

endpackage

`default_nettype wire

[src/sle_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sle_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 28
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read port that holds its data when not enabled.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/serial_link_frame_engine.sv]
// Top level of the serial link frame engine: control, checksum sweep and result pipeline.
//
// Usage: the host sends items on the in_ channel (valid/stall). Action 0 writes
// one word of the staging frame, action 1 commits it (word 1 becomes the
// checksum and a swap is armed), action 2 is one link transfer event carrying
// both received words and the serial error bit. Each accepted item yields
// exactly one result on the out_ channel (valid/stall): the next send word,
// the received words with their frame position, frame_done with slot_ok at
// the last position, and the captured error bit.
// A result passes through the middle stage and the result register.
// Throughput: one item per cycle while the input is not stalled. After a
// commit is accepted the input is stalled while the checksum unit reads
// the staging frame one word per cycle through the frame store read port
// and then writes word 1.
// cfg_we/cfg_wdata write is_parent; write it only while the block is idle.
// Reset (rst_n low, synchronous) clears the control state; the frame store
// is not cleared and holds undefined words until the host writes them.
// When the receiver stalls, the result register holds; one more item may
// sit in the middle stage, after which in_stall is raised.
`default_nettype none

module serial_link_frame_engine #(
  parameter int FRAME_WORDS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [3:0]  in_word_index,
  input  wire logic [15:0] in_word_value,
  input  wire logic [15:0] in_recv_slot0,
  input  wire logic [15:0] in_recv_slot1,
  input  wire logic        in_link_error_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_send_word,
  output logic             out_send_valid,
  output logic             out_start_next,
  output logic [3:0]       out_rx_position,
  output logic             out_rx_valid,
  output logic [15:0]      out_rx_word0,
  output logic [15:0]      out_rx_word1,
  output logic             out_frame_done,
  output logic [1:0]       out_slot_ok,
  output logic             out_link_error
);

  import sle_pkg::*;

  localparam int DEPTH  = 2 * FRAME_WORDS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = $clog2(FRAME_WORDS + 2);
  localparam int RPOS_W = $clog2(FRAME_WORDS + 3);
  localparam int SW_W   = $clog2(FRAME_WORDS + 1);

  localparam logic [ADDR_W-1:0] BANK1_BASE = ADDR_W'(FRAME_WORDS);
  localparam logic [POS_W-1:0]  SPOS_END   = POS_W'(FRAME_WORDS);
  localparam logic [POS_W-1:0]  SPOS_IDLE  = POS_W'(FRAME_WORDS + 1);
  localparam logic [RPOS_W-1:0] RPOS_END   = RPOS_W'(FRAME_WORDS);
  localparam logic [RPOS_W-1:0] RPOS_SYNC  = RPOS_W'(FRAME_WORDS + 1);
  localparam logic [RPOS_W-1:0] RPOS_IDLE  = RPOS_W'(FRAME_WORDS + 2);
  localparam logic [RPOS_W-1:0] RPOS_LAST  = RPOS_W'(FRAME_WORDS - 1);
  localparam logic [SW_W-1:0]   SW_END     = SW_W'(FRAME_WORDS);
  localparam logic [4:0]        IDX_END    = 5'(FRAME_WORDS);

  // Control state. The receive position is stored one above the frame
  // position so that the just-synced position is zero.
  logic              is_parent_r, is_parent_nxt;
  logic              send_bank_r, send_bank_nxt;
  logic              swap_pend_r, swap_pend_nxt;
  logic [POS_W-1:0]  spos_r, spos_nxt;
  logic [RPOS_W-1:0] rpos_r, rpos_nxt;
  logic [15:0]       sum0_r, sum0_nxt;
  logic [15:0]       sum1_r, sum1_nxt;
  logic              cap_err_r, cap_err_nxt;

  // Checksum sweep state.
  logic              sw_busy_r, sw_busy_nxt;
  logic [SW_W-1:0]   sw_idx_r, sw_idx_nxt;
  logic              sw_dv_r, sw_dv_nxt;
  logic [15:0]       sw_acc_r, sw_acc_nxt;

  // Middle stage and result register.
  logic              s1_valid_r, s1_valid_nxt;
  sle_result_t       s1_res_r, s1_res_nxt;
  logic              out_valid_r, out_valid_nxt;
  sle_result_t       out_res_r, out_res_nxt;
  logic [15:0]       out_word_r, out_word_nxt;

  // Frame store ports.
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [15:0]       ram_wdata, ram_rdata;

  // Decode of the incoming item.
  logic              s1_adv, in_acc, is_xfer, is_write, is_commit;
  logic              sync, swap, bank_eff, snd_vld, rx_vld, stage_bank;
  logic [POS_W-1:0]  spos_eff, spos_inc;
  logic [RPOS_W-1:0] rpos_eff, rpos_inc, rx_pos;
  logic [7:0]        rx_pos_ext;
  logic [15:0]       new_sum0, new_sum1, sw_total;
  logic              wr_ok, sw_rd, sw_wr;
  logic [ADDR_W-1:0] xfer_addr, wr_addr, sw_addr, word1_addr;

  sle_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake: the middle stage moves on whenever the result register is empty or not stalled.
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = sw_busy_r || (s1_valid_r && !s1_adv);
  assign in_acc    = in_valid && !in_stall;
  assign is_xfer   = (in_action == ACT_XFER);
  assign is_write  = (in_action == ACT_WRITE);
  assign is_commit = (in_action == ACT_COMMIT);

  // Sync detection, send and receive positions for a transfer event.
  always_comb begin
    stage_bank = !send_bank_r;
    sync       = (in_recv_slot0 == SYNC_WORD) && (rpos_r >= RPOS_SYNC);
    swap       = sync && swap_pend_r;
    bank_eff   = send_bank_r ^ swap;
    spos_eff   = swap ? '0 : spos_r;
    snd_vld    = (spos_eff < SPOS_END);
    spos_inc   = (spos_eff < SPOS_IDLE) ? spos_eff + POS_W'(1) : spos_eff;
    rpos_eff   = sync ? '0 : rpos_r;
    rx_vld     = (rpos_eff != '0) && (rpos_eff <= RPOS_END);
    rx_pos     = rpos_eff - RPOS_W'(1);
    rx_pos_ext = 8'(rx_pos);
    rpos_inc   = (rpos_eff < RPOS_IDLE) ? rpos_eff + RPOS_W'(1) : rpos_eff;
    new_sum0   = (rx_pos == '0) ? in_recv_slot0 : sum0_r + in_recv_slot0;
    new_sum1   = (rx_pos == '0) ? in_recv_slot1 : sum1_r + in_recv_slot1;
    xfer_addr  = (bank_eff ? BANK1_BASE : '0) + ADDR_W'(spos_eff);
    wr_addr    = (stage_bank ? BANK1_BASE : '0) + ADDR_W'(in_word_index);
    wr_ok      = (in_word_index != 4'd1) && ({1'b0, in_word_index} < IDX_END);
  end

  // Checksum sweep: read words 0 and 2 onward, then write word 1.
  always_comb begin
    sw_rd      = sw_busy_r && (sw_idx_r < SW_END);
    sw_wr      = sw_busy_r && (sw_idx_r == SW_END) && sw_dv_r;
    sw_addr    = (stage_bank ? BANK1_BASE : '0) + ADDR_W'(sw_idx_r);
    word1_addr = (stage_bank ? BANK1_BASE : '0) + ADDR_W'(1);
    sw_total   = sw_acc_r + ram_rdata;
    sw_busy_nxt = sw_busy_r;
    sw_idx_nxt  = sw_idx_r;
    sw_dv_nxt   = sw_dv_r;
    sw_acc_nxt  = sw_acc_r;
    if (in_acc && is_commit) begin
      sw_busy_nxt = 1'b1;
      sw_idx_nxt  = '0;
      sw_dv_nxt   = 1'b0;
      sw_acc_nxt  = '0;
    end else if (sw_busy_r) begin
      sw_dv_nxt = sw_rd;
      if (sw_rd) begin
        sw_idx_nxt = (sw_idx_r == '0) ? SW_W'(2) : sw_idx_r + SW_W'(1);
      end
      if (sw_dv_r) begin
        sw_acc_nxt = sw_total;
      end
      if (sw_wr) begin
        sw_busy_nxt = 1'b0;
      end
    end
  end

  // Frame store port selection.
  always_comb begin
    ram_we    = sw_wr || (in_acc && is_write && wr_ok);
    ram_waddr = sw_wr ? word1_addr : wr_addr;
    ram_wdata = sw_wr ? (~sw_total - SUM_BIAS) : in_word_value;
    ram_re    = sw_rd || (in_acc && is_xfer);
    ram_raddr = sw_rd ? sw_addr : xfer_addr;
  end

  // Control state update and the result of the accepted item.
  always_comb begin
    is_parent_nxt = cfg_we ? cfg_wdata : is_parent_r;
    send_bank_nxt = send_bank_r;
    swap_pend_nxt = swap_pend_r;
    spos_nxt      = spos_r;
    rpos_nxt      = rpos_r;
    sum0_nxt      = sum0_r;
    sum1_nxt      = sum1_r;
    cap_err_nxt   = cap_err_r;
    s1_res_nxt    = '0;
    if (in_acc && is_commit) begin
      swap_pend_nxt = 1'b1;
    end
    if (in_acc && is_xfer) begin
      cap_err_nxt   = in_link_error_in;
      send_bank_nxt = bank_eff;
      if (swap) begin
        swap_pend_nxt = 1'b0;
      end
      spos_nxt = spos_inc;
      rpos_nxt = rpos_inc;
      if (rx_vld) begin
        sum0_nxt = new_sum0;
        sum1_nxt = new_sum1;
        s1_res_nxt.rx_valid    = 1'b1;
        s1_res_nxt.rx_position = rx_pos_ext[3:0];
        s1_res_nxt.rx_word0    = in_recv_slot0;
        s1_res_nxt.rx_word1    = in_recv_slot1;
        if (rx_pos == RPOS_LAST) begin
          s1_res_nxt.frame_done = 1'b1;
          s1_res_nxt.slot_ok    = {new_sum1 == PASS_SUM, new_sum0 == PASS_SUM};
        end
      end
      s1_res_nxt.send_valid = snd_vld;
      s1_res_nxt.start_next = is_parent_r && (spos_inc < SPOS_IDLE);
    end
    s1_res_nxt.link_error = cap_err_nxt;
  end

  // Pipeline advance.
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_word_nxt  = out_word_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
      out_res_nxt   = s1_res_r;
      out_word_nxt  = s1_res_r.send_valid ? ram_rdata : '0;
      s1_valid_nxt  = 1'b0;
    end
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_parent_r <= 1'b0;
      send_bank_r <= 1'b0;
      swap_pend_r <= 1'b0;
      spos_r      <= SPOS_IDLE;
      rpos_r      <= RPOS_IDLE;
      sum0_r      <= '0;
      sum1_r      <= '0;
      cap_err_r   <= 1'b0;
      sw_busy_r   <= 1'b0;
      sw_dv_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      is_parent_r <= is_parent_nxt;
      send_bank_r <= send_bank_nxt;
      swap_pend_r <= swap_pend_nxt;
      spos_r      <= spos_nxt;
      rpos_r      <= rpos_nxt;
      sum0_r      <= sum0_nxt;
      sum1_r      <= sum1_nxt;
      cap_err_r   <= cap_err_nxt;
      sw_busy_r   <= sw_busy_nxt;
      sw_dv_r     <= sw_dv_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sw_idx_r  <= sw_idx_nxt;
    sw_acc_r  <= sw_acc_nxt;
    out_res_r <= out_res_nxt;
    out_word_r <= out_word_nxt;
    if (in_acc) begin
      s1_res_r <= s1_res_nxt;
    end
  end

  // Result ports.
  assign out_valid       = out_valid_r;
  assign out_send_word   = out_word_r;
  assign out_send_valid  = out_res_r.send_valid;
  assign out_start_next  = out_res_r.start_next;
  assign out_rx_position = out_res_r.rx_position;
  assign out_rx_valid    = out_res_r.rx_valid;
  assign out_rx_word0    = out_res_r.rx_word0;
  assign out_rx_word1    = out_res_r.rx_word1;
  assign out_frame_done  = out_res_r.frame_done;
  assign out_slot_ok     = out_res_r.slot_ok;
  assign out_link_error  = out_res_r.link_error;

endmodule

`default_nettype wire

[src/sle_checker.sv]
// Port-level assertions for the serial link frame engine and their bind.
`default_nettype none

module sle_checker #(
  parameter int FRAME_WORDS = 14
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_action,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_send_word,
  input wire logic        out_rx_valid,
  input wire logic [3:0]  out_rx_position,
  input wire logic        out_frame_done
);

  import sle_pkg::*;

  localparam logic [3:0] LAST_POS = 4'(FRAME_WORDS - 1);

  // No result is shown right after a reset cycle.
  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // A committed frame blocks the input while its checksum is built.
  a_commit_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_action == ACT_COMMIT)) |=> in_stall)
    else $error("input not stalled after a commit transfer");

  // A finished frame is reported only with its last position.
  a_frame_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> (out_rx_valid && (out_rx_position == LAST_POS)))
    else $error("frame_done without the last frame position");

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_send_word)))
    else $error("stalled result changed");

endmodule

bind serial_link_frame_engine sle_checker #(
  .FRAME_WORDS (FRAME_WORDS)
) u_sle_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_action       (in_action),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_send_word   (out_send_word),
  .out_rx_valid    (out_rx_valid),
  .out_rx_position (out_rx_position),
  .out_frame_done  (out_frame_done)
);

`default_nettype wire
